FILE: rtl/core/ucr_pkg.sv
// ----------------------------------------------------------------------------
// ucr_pkg: shared types and constants of the UTF-8 character reverser
// Store sizes, derived address widths, opcode and response codes, controller
// states, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ucr_pkg;

   // Store sizes
   localparam int MAX_CHARS = 512;
   localparam int MAX_BYTES = 2048;

   // Address widths index the stores, count widths can hold the full depth
   localparam int BYTE_AW = $clog2(MAX_BYTES);
   localparam int CHAR_AW = $clog2(MAX_CHARS);
   localparam int BYTE_CW = $clog2(MAX_BYTES + 1);
   localparam int CHAR_CW = $clog2(MAX_CHARS + 1);

   // Payload widths
   localparam int OPCODE_W = 2;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 2'd0,
      OP_CLOSE  = 2'd1,
      OP_READ   = 2'd2
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_PHASE = 2'd2,
      ST_EMPTY = 2'd3
   } rsp_code_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CLOSE_WAIT,
      S_READ_WAIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic         append;
      logic         close_issue;
      logic         close_finish;
      logic         read_issue;
      logic         read_finish;
      logic         rsp_load;
      rsp_code_type rsp_code;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic reading_phase;
      logic store_full;
      logic read_empty;
      logic out_free;
   } stat_type;

   // Number of continuation bytes that follow a lead byte
   function automatic logic [1:0] extra_bytes(input logic [DATA_W-1:0] lead);
      logic [1:0] n;
      n = 2'd0;
      if (lead[7] == 1'b0) begin
         n = 2'd0;
      end else if ((lead & 8'hE0) == 8'hC0) begin
         n = 2'd1;
      end else if ((lead & 8'hF0) == 8'hE0) begin
         n = 2'd2;
      end else if ((lead & 8'hF8) == 8'hF0) begin
         n = 2'd3;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ucr_req_if.sv
// ----------------------------------------------------------------------------
// ucr_req_if: request channel of the UTF-8 character reverser
// Valid/ready channel carrying an opcode and a string byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ucr_req_if;
   logic                         valid;
   logic                         ready;
   logic [ucr_pkg::OPCODE_W-1:0] opcode;
   logic [ucr_pkg::DATA_W-1:0]   data_byte;

   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ucr_rsp_if.sv
// ----------------------------------------------------------------------------
// ucr_rsp_if: response channel of the UTF-8 character reverser
// Valid/ready channel carrying one result item per request item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ucr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ucr_pkg::DATA_W-1:0]   out_byte;
   logic                         out_valid;
   logic                         out_last;
   logic [ucr_pkg::STATUS_W-1:0] status;

   modport source (output valid, output out_byte, output out_valid, output out_last,
                   output status, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input out_last,
                   input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ucr_ctrl.sv
// ----------------------------------------------------------------------------
// ucr_ctrl: controller of the UTF-8 character reverser
// Decodes each request item against the datapath status and sequences the
// registered store read that close and read items need.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucr_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [ucr_pkg::OPCODE_W-1:0] req_opcode,
   input  wire logic                         req_data_zero,
   input  wire ucr_pkg::stat_type            stat,
   output      ucr_pkg::cmd_type             cmd
);
   import ucr_pkg::*;

   state_type    state_ff;
   state_type    state_in;
   logic         accept;
   logic         want_append;
   logic         want_close;
   logic         want_read;
   logic         imm_load;
   rsp_code_type imm_code;

   // Take an item only when idle and the result register can receive
   assign req_ready = (state_ff == S_IDLE) && stat.out_free;
   assign accept    = req_valid && req_ready;

   // Decode the request against the current phase
   always_comb begin
      want_append = 1'b0;
      want_close  = 1'b0;
      want_read   = 1'b0;
      imm_load    = 1'b0;
      imm_code    = ST_OK;
      unique case (opcode_type'(req_opcode)) inside
         OP_APPEND, OP_CLOSE: begin
            if (stat.reading_phase) begin
               imm_load = 1'b1;
               imm_code = ST_PHASE;
            end else if ((opcode_type'(req_opcode) == OP_CLOSE) || req_data_zero) begin
               want_close = 1'b1;
            end else if (stat.store_full) begin
               imm_load = 1'b1;
               imm_code = ST_FULL;
            end else begin
               want_append = 1'b1;
               imm_load    = 1'b1;
               imm_code    = ST_OK;
            end
         end
         OP_READ: begin
            if (!stat.reading_phase) begin
               imm_load = 1'b1;
               imm_code = ST_PHASE;
            end else if (stat.read_empty) begin
               imm_load = 1'b1;
               imm_code = ST_EMPTY;
            end else begin
               want_read = 1'b1;
            end
         end
         default: begin
            imm_load = 1'b1;
            imm_code = ST_PHASE;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && want_close) begin
               state_in = S_CLOSE_WAIT;
            end else if (accept && want_read) begin
               state_in = S_READ_WAIT;
            end
         end
         S_CLOSE_WAIT, S_READ_WAIT: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.append      = want_append;
               cmd.close_issue = want_close;
               cmd.read_issue  = want_read;
               cmd.rsp_load    = imm_load;
               cmd.rsp_code    = imm_code;
            end
         end
         S_CLOSE_WAIT: begin
            if (stat.out_free) begin
               cmd.close_finish = 1'b1;
               cmd.rsp_load     = 1'b1;
               cmd.rsp_code     = ST_OK;
            end
         end
         S_READ_WAIT: begin
            if (stat.out_free) begin
               cmd.read_finish = 1'b1;
               cmd.rsp_load    = 1'b1;
               cmd.rsp_code    = ST_OK;
            end
         end
         default: cmd = '0;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/ucr_datapath.sv
// ----------------------------------------------------------------------------
// ucr_datapath: stores, counters and result register of the reverser
// Holds the byte store and the character start store, the load counters,
// the read cursor and the registered result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucr_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [ucr_pkg::DATA_W-1:0]   req_data_byte,
   input  wire ucr_pkg::cmd_type             cmd,
   output      ucr_pkg::stat_type            stat,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [ucr_pkg::DATA_W-1:0]   rsp_out_byte,
   output      logic                         rsp_out_valid,
   output      logic                         rsp_out_last,
   output      logic [ucr_pkg::STATUS_W-1:0] rsp_status
);
   import ucr_pkg::*;

   // Stores
   logic [DATA_W-1:0]  byte_mem  [MAX_BYTES];
   logic [BYTE_AW-1:0] start_mem [MAX_CHARS];

   // Load state
   logic [BYTE_CW-1:0] byte_total_ff, byte_total_in;
   logic [CHAR_CW-1:0] char_total_ff, char_total_in;
   logic [1:0]         absorb_ff, absorb_in;
   logic               phase_ff, phase_in;

   // Read cursor
   logic [CHAR_CW-1:0] rd_cidx_ff, rd_cidx_in;
   logic [BYTE_CW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [BYTE_CW-1:0] rd_start_ff, rd_start_in;
   logic [BYTE_CW-1:0] rd_end_ff, rd_end_in;

   // Registered store read data
   logic [DATA_W-1:0]  byte_rd_ff;
   logic [BYTE_AW-1:0] start_rd_ff;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_oval_ff, rsp_oval_in;
   logic               rsp_last_ff, rsp_last_in;
   rsp_code_type       rsp_code_ff, rsp_code_in;

   logic               new_char;
   logic [CHAR_CW-1:0] start_raddr;
   logic [BYTE_CW-1:0] ptr_next;
   logic [CHAR_CW-1:0] cidx_next;
   logic [BYTE_CW-1:0] start_ext;
   logic               char_done;
   logic               more_chars;

   // Status toward the controller
   assign stat.reading_phase = phase_ff;
   assign stat.store_full    = (byte_total_ff >= BYTE_CW'(MAX_BYTES));
   assign stat.read_empty    = (rd_cidx_ff >= char_total_ff) || (rd_ptr_ff >= byte_total_ff);
   assign stat.out_free      = !rsp_valid_ff || rsp_ready;

   // A byte starts a character when nothing is pending and room is left
   assign new_char = (absorb_ff == 2'd0) && (char_total_ff < CHAR_CW'(MAX_CHARS));

   // Start store read address: last character on close, next one on read
   assign start_raddr = cmd.close_issue ? (char_total_ff - CHAR_CW'(1))
                                        : (char_total_ff - CHAR_CW'(2) - rd_cidx_ff);

   // Read cursor arithmetic
   assign ptr_next   = rd_ptr_ff + BYTE_CW'(1);
   assign cidx_next  = rd_cidx_ff + CHAR_CW'(1);
   assign start_ext  = BYTE_CW'(start_rd_ff);
   assign char_done  = (ptr_next >= rd_end_ff);
   assign more_chars = (cidx_next < char_total_ff);

   // Next values of load state, cursor and result
   always_comb begin
      byte_total_in = byte_total_ff;
      char_total_in = char_total_ff;
      absorb_in     = absorb_ff;
      phase_in      = phase_ff;
      rd_cidx_in    = rd_cidx_ff;
      rd_ptr_in     = rd_ptr_ff;
      rd_start_in   = rd_start_ff;
      rd_end_in     = rd_end_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_oval_in   = rsp_oval_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_code_in   = rsp_code_ff;

      // Append one byte, opening a character or absorbing a continuation
      if (cmd.append) begin
         byte_total_in = byte_total_ff + BYTE_CW'(1);
         if (absorb_ff != 2'd0) begin
            absorb_in = absorb_ff - 2'd1;
         end else if (new_char) begin
            char_total_in = char_total_ff + CHAR_CW'(1);
            absorb_in     = extra_bytes(req_data_byte);
         end
      end

      // Close: point at the last character
      if (cmd.close_finish) begin
         phase_in   = 1'b1;
         rd_cidx_in = '0;
         rd_end_in  = byte_total_ff;
         if (char_total_ff != '0) begin
            rd_ptr_in   = start_ext;
            rd_start_in = start_ext;
         end else begin
            rd_ptr_in   = '0;
            rd_start_in = '0;
         end
      end

      // Read: advance within the character, then step to the previous one
      if (cmd.read_finish) begin
         rd_ptr_in = ptr_next;
         if (char_done) begin
            rd_cidx_in = cidx_next;
            if (more_chars) begin
               rd_ptr_in   = start_ext;
               rd_start_in = start_ext;
               rd_end_in   = rd_start_ff;
            end
         end
      end

      // Result register: load or drain
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = cmd.rsp_code;
         if (cmd.read_finish) begin
            rsp_byte_in = byte_rd_ff;
            rsp_oval_in = 1'b1;
            rsp_last_in = char_done && !more_chars;
         end else begin
            rsp_byte_in = '0;
            rsp_oval_in = 1'b0;
            rsp_last_in = 1'b0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_total_ff <= '0;
         char_total_ff <= '0;
         absorb_ff     <= '0;
         phase_ff      <= 1'b0;
         rd_cidx_ff    <= '0;
         rd_ptr_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_total_ff <= byte_total_in;
         char_total_ff <= char_total_in;
         absorb_ff     <= absorb_in;
         phase_ff      <= phase_in;
         rd_cidx_ff    <= rd_cidx_in;
         rd_ptr_ff     <= rd_ptr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_start_ff <= rd_start_in;
      rd_end_ff   <= rd_end_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_oval_ff <= rsp_oval_in;
      rsp_last_ff <= rsp_last_in;
      rsp_code_ff <= rsp_code_in;
   end

   // Byte store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         byte_mem[byte_total_ff[BYTE_AW-1:0]] <= req_data_byte;
      end
      if (cmd.read_issue) begin
         byte_rd_ff <= byte_mem[rd_ptr_ff[BYTE_AW-1:0]];
      end
   end

   // Start store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.append && (absorb_ff == 2'd0) && new_char) begin
         start_mem[char_total_ff[CHAR_AW-1:0]] <= byte_total_ff[BYTE_AW-1:0];
      end
      if (cmd.read_issue || cmd.close_issue) begin
         start_rd_ff <= start_mem[start_raddr[CHAR_AW-1:0]];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_out_valid = rsp_oval_ff;
   assign rsp_out_last  = rsp_last_ff;
   assign rsp_status    = rsp_code_ff;

   // Results are never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.out_free)
      else $error("result register overwritten while stalled");

   // Counters stay within the store sizes
   a_totals_bound: assert property (@(posedge clock) disable iff (reset)
      (byte_total_ff <= BYTE_CW'(MAX_BYTES)) && (char_total_ff <= CHAR_CW'(MAX_CHARS))
      && (BYTE_CW'(char_total_ff) <= byte_total_ff))
      else $error("byte or character total out of range");

   // Loading only happens in the loading phase
   a_append_phase: assert property (@(posedge clock) disable iff (reset)
      (cmd.append || cmd.close_issue) |-> !phase_ff)
      else $error("load command while reading");

   // While characters remain, the cursor lies inside the current character
   a_cursor_inside: assert property (@(posedge clock) disable iff (reset)
      (phase_ff && (rd_cidx_ff < char_total_ff)) |-> (rd_ptr_ff < rd_end_ff))
      else $error("read cursor outside current character");

   // A finished read always delivers a byte with an ok code
   a_read_result: assert property (@(posedge clock) disable iff (reset)
      cmd.read_finish |=> (rsp_valid_ff && rsp_oval_ff && (rsp_code_ff == ST_OK)))
      else $error("read result not delivered");

endmodule

`default_nettype wire

FILE: rtl/core/utf8_character_reverser.sv
// ----------------------------------------------------------------------------
// utf8_character_reverser: load a UTF-8 string, read it back reversed
//
// Usage: send items on req_ch (valid/ready). Opcode append stores data_byte,
// close (or an append of a zero byte) ends loading, read returns the next
// byte of the string in reversed character order; each character keeps its
// own byte order. Every item yields exactly one result item on rsp_ch with
// out_byte, out_valid, out_last and a status code.
// Latency: appends and rejected items give their result in the cycle after
// acceptance; close and read items give theirs after the registered read of
// the byte store and the character start store, taking no new item meanwhile.
// Throughput: one append per cycle while the result register can receive.
// The result register parts the channels: a new item is taken while the
// previous result is drained in the same cycle. When the receiver stalls,
// the result holds and no new item is taken.
// Reset clears the counters, the read cursor and the result register and
// returns to the loading phase; the stores are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module utf8_character_reverser (
   input wire logic clock,
   input wire logic reset,
   ucr_req_if.sink  req_ch,
   ucr_rsp_if.source rsp_ch
);
   import ucr_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     data_zero;

   // Zero byte on append acts as close
   assign data_zero = (req_ch.data_byte == '0);

   // Sequence items
   ucr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_opcode    (req_ch.opcode),
      .req_data_zero (data_zero),
      .stat          (stat),
      .cmd           (cmd)
   );

   // Stores, cursor and result register
   ucr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_ch.data_byte),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_out_byte  (rsp_ch.out_byte),
      .rsp_out_valid (rsp_ch.out_valid),
      .rsp_out_last  (rsp_ch.out_last),
      .rsp_status    (rsp_ch.status)
   );

endmodule

`default_nettype wire

FILE: sim/utf8_character_reverser_test.sv
// ----------------------------------------------------------------------------
// utf8_character_reverser_test: self-checking bench for the UTF-8 reverser
// Loads one string (well-formed characters with random content, stray and
// broken sequences, out-of-phase items) of a few hundred bytes. It then
// closes the string and reads it all back, past the end. Every result item
// is checked against an in-bench model of the reversal. The sender works in
// bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_character_reverser_test;
   import ucr_pkg::*;

   // Opcode value the block does not define
   localparam logic [OPCODE_W-1:0] OP_UNDEFINED = 2'd3;

   // Cycles with no item moving on either channel before giving up
   localparam int IDLE_LIMIT = 1000;
   // Cycles allowed after the last result for a late, unexpected item
   localparam int SETTLE_CYCLES = 10;
   localparam int REPORT_LIMIT = 10;
   // Byte count the random load runs up to before the close; sets the length of the run
   localparam int LOAD_BYTES = 460;

   typedef struct packed {
      logic [DATA_W-1:0] out_byte;
      logic              out_valid;
      logic              out_last;
      rsp_code_type      status;
   } reversal_result_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [DATA_W-1:0]   data_byte;
      logic                typed;
      reversal_result_type want;
   } text_stim_type;

   localparam reversal_result_type RSP_OK    = '{8'h00, 1'b0, 1'b0, ST_OK};
   localparam reversal_result_type RSP_PHASE = '{8'h00, 1'b0, 1'b0, ST_PHASE};

   logic clock;
   logic reset;

   ucr_req_if req_ch();
   ucr_rsp_if rsp_ch();

   utf8_character_reverser dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Opening items: reads and undefined opcode while loading, extreme lead
   // bytes of each length, stray continuation and invalid leads, and a
   // non-continuation byte absorbed into a two-byte character
   text_stim_type directed_rows [20] = '{
      '{OP_READ,      8'h5A, 1'b1, RSP_PHASE},
      '{OP_UNDEFINED, 8'hA5, 1'b1, RSP_PHASE},
      '{OP_APPEND,    8'h01, 1'b1, RSP_OK},
      '{OP_APPEND,    8'h7F, 1'b1, RSP_OK},
      '{OP_APPEND,    8'hC2, 1'b0, RSP_OK},
      '{OP_APPEND,    8'h80, 1'b0, RSP_OK},
      '{OP_APPEND,    8'hDF, 1'b0, RSP_OK},
      '{OP_APPEND,    8'hBF, 1'b0, RSP_OK},
      '{OP_APPEND,    8'hE0, 1'b0, RSP_OK},
      '{OP_APPEND,    8'hA0, 1'b0, RSP_OK},
      '{OP_APPEND,    8'h80, 1'b0, RSP_OK},
      '{OP_APPEND,    8'hF4, 1'b0, RSP_OK},
      '{OP_APPEND,    8'h8F, 1'b0, RSP_OK},
      '{OP_APPEND,    8'hBF, 1'b0, RSP_OK},
      '{OP_APPEND,    8'hBF, 1'b0, RSP_OK},
      '{OP_APPEND,    8'h80, 1'b1, RSP_OK},
      '{OP_APPEND,    8'hFF, 1'b1, RSP_OK},
      '{OP_APPEND,    8'hF8, 1'b1, RSP_OK},
      '{OP_APPEND,    8'hC3, 1'b0, RSP_OK},
      '{OP_APPEND,    8'h41, 1'b0, RSP_OK}
   };

   // Model state of the string being reversed
   logic [DATA_W-1:0] text_bytes   [MAX_BYTES];
   int                char_offsets [MAX_CHARS];
   int                byte_count   = 0;
   int                chars_loaded = 0;
   int                pending_cont = 0;
   bit                in_readout   = 1'b0;
   int                chars_done   = 0;
   int                read_addr    = 0;

   reversal_result_type pending_results [$];

   int burst_left       = 0;
   int mismatch_count   = 0;
   int unexpected_count = 0;
   int delivered_count  = 0;
   int status_tally [4] = '{0, 0, 0, 0};
   int idle_cycles      = 0;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Continuation bytes announced by a lead byte
   function automatic int continuation_count(input logic [DATA_W-1:0] lead);
      casez (lead)
         8'b110?????: return 1;
         8'b1110????: return 2;
         8'b11110???: return 3;
         default:     return 0;
      endcase
   endfunction

   // Advance the model by one item and return the result it gives
   function automatic reversal_result_type reverse_step(input logic [OPCODE_W-1:0] op,
                                                        input logic [DATA_W-1:0]   b);
      reversal_result_type r;
      int                  ci;
      int                  char_end;
      r = RSP_OK;
      case (op) inside
         OP_APPEND, OP_CLOSE: begin
            if (in_readout) begin
               r.status = ST_PHASE;
            end else if (op == OP_CLOSE || b == 8'h00) begin
               in_readout = 1'b1;
               chars_done = 0;
               read_addr  = (chars_loaded > 0) ? char_offsets[chars_loaded-1] : 0;
            end else if (byte_count >= MAX_BYTES) begin
               r.status = ST_FULL;
            end else begin
               if (pending_cont > 0) begin
                  pending_cont--;
               end else if (chars_loaded < MAX_CHARS) begin
                  char_offsets[chars_loaded] = byte_count;
                  chars_loaded++;
                  pending_cont = continuation_count(b);
               end
               text_bytes[byte_count] = b;
               byte_count++;
            end
         end
         OP_READ: begin
            if (!in_readout) begin
               r.status = ST_PHASE;
            end else if (chars_done >= chars_loaded || read_addr >= byte_count) begin
               r.status = ST_EMPTY;
            end else begin
               ci       = chars_loaded - 1 - chars_done;
               char_end = (ci + 1 < chars_loaded) ? char_offsets[ci+1] : byte_count;
               r.out_byte  = text_bytes[read_addr];
               r.out_valid = 1'b1;
               read_addr++;
               // Jump back to the start of the previous character when done
               if (read_addr >= char_end) begin
                  chars_done++;
                  if (chars_done < chars_loaded) begin
                     read_addr = char_offsets[chars_loaded-1-chars_done];
                  end else begin
                     r.out_last = 1'b1;
                  end
               end
            end
         end
         default: begin
            r.status = ST_PHASE;
         end
      endcase
      return r;
   endfunction

   // Offer one item, wait for it to be taken, record the result it must give
   task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [DATA_W-1:0] b,
                            input logic typed, input reversal_result_type want);
      reversal_result_type predicted;
      int                  gap;
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= op;
      req_ch.data_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      predicted = reverse_step(op, b);
      pending_results.push_back(typed ? want : predicted);
      // End the burst with a gap, then pick the next burst length
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         burst_left = ($urandom_range(3) == 0) ? $urandom_range(150, 300)
                                              : $urandom_range(1, 30);
      end
   endtask

   // Hold the sender until every expected result has come back
   task automatic hold_until_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Item that loading ignores: a read or an undefined opcode
   task automatic send_loading_noise();
      if ($urandom_range(1) == 1) begin
         send_item(OP_READ, 8'($urandom_range(255)), 1'b0, RSP_OK);
      end else begin
         send_item(OP_UNDEFINED, 8'($urandom_range(255)), 1'b0, RSP_OK);
      end
   endtask

   // Append one character: mostly well-formed, sometimes stray or broken
   task automatic append_random_char();
      int                kind;
      int                len;
      int                i;
      logic [DATA_W-1:0] lead;
      kind = $urandom_range(99);
      if (kind < 8) begin
         send_loading_noise();
      end else if (kind < 16) begin
         // stray continuation byte or invalid lead
         lead = ($urandom_range(1) == 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                         : 8'($urandom_range(8'hF8, 8'hFF));
         send_item(OP_APPEND, lead, 1'b0, RSP_OK);
      end else if (kind < 22) begin
         // lead followed by bytes of any nonzero value, count random
         send_item(OP_APPEND, 8'($urandom_range(8'hC0, 8'hF7)), 1'b0, RSP_OK);
         len = $urandom_range(0, 3);
         for (i = 0; i < len; i++) begin
            send_item(OP_APPEND, 8'($urandom_range(1, 255)), 1'b0, RSP_OK);
         end
      end else begin
         len = $urandom_range(1, 4);
         case (len)
            1:       lead = 8'($urandom_range(8'h01, 8'h7F));
            2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
            3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hF7));
         endcase
         send_item(OP_APPEND, lead, 1'b0, RSP_OK);
         for (i = 1; i < len; i++) begin
            if ($urandom_range(19) == 0) send_loading_noise();
            send_item(OP_APPEND, 8'($urandom_range(8'h80, 8'hBF)), 1'b0, RSP_OK);
         end
      end
   endtask

   // Item that reading ignores: append (zero byte too), close or undefined
   task automatic send_readout_noise();
      case ($urandom_range(2))
         0:       send_item(OP_APPEND, 8'($urandom_range(255)), 1'b0, RSP_OK);
         1:       send_item(OP_CLOSE, 8'($urandom_range(255)), 1'b0, RSP_OK);
         default: send_item(OP_UNDEFINED, 8'($urandom_range(255)), 1'b0, RSP_OK);
      endcase
   endtask

   // Receiver: switch among ready, random, periodic and long-stall patterns
   initial begin : receiver_pattern
      int mode;
      int mode_left;
      int phase;
      mode         = 0;
      mode_left    = 0;
      phase        = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(3);
            mode_left = $urandom_range(10, 80);
            phase     = 0;
         end
         mode_left--;
         phase++;
         case (mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(99) < 70);
            2:       rsp_ch.ready <= (phase % 3 != 0);
            default: rsp_ch.ready <= (phase % 20 >= 15);
         endcase
      end
   end

   // Compare each result item with the oldest expectation
   always @(posedge clock) begin
      reversal_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (rsp_ch.out_valid) delivered_count++;
         status_tally[rsp_ch.status]++;
         if (pending_results.size() == 0) begin
            unexpected_count++;
            if (mismatch_count + unexpected_count <= REPORT_LIMIT) begin
               $display("unexpected result item: byte %02h valid %0b last %0b status %0d",
                        rsp_ch.out_byte, rsp_ch.out_valid, rsp_ch.out_last, rsp_ch.status);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.out_byte !== want.out_byte || rsp_ch.out_valid !== want.out_valid ||
                rsp_ch.out_last !== want.out_last || rsp_ch.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count + unexpected_count <= REPORT_LIMIT) begin
                  $display("mismatch: expected byte %02h valid %0b last %0b status %0d, %s",
                           want.out_byte, want.out_valid, want.out_last, want.status,
                           $sformatf("got byte %02h valid %0b last %0b status %0d",
                                     rsp_ch.out_byte, rsp_ch.out_valid, rsp_ch.out_last,
                                     rsp_ch.status));
               end
            end
         end
      end
   end

   // Give up when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus
   initial begin : stimulus
      int i;
      req_ch.valid     = 1'b0;
      req_ch.opcode    = OP_APPEND;
      req_ch.data_byte = 8'h00;
      reset            = 1'b1;
      burst_left       = $urandom_range(1, 30);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         send_item(directed_rows[k].opcode, directed_rows[k].data_byte,
                   directed_rows[k].typed, directed_rows[k].want);
      end

      // Load a string of mixed characters, ending with a few arbitrary bytes
      while (byte_count < LOAD_BYTES) append_random_char();
      for (i = 0; i < 6; i++) begin
         send_item(OP_APPEND, 8'($urandom_range(1, 255)), 1'b0, RSP_OK);
      end

      // Close by opcode or by a zero byte, after a full drain
      hold_until_drained();
      if ($urandom_range(1) == 1) begin
         send_item(OP_CLOSE, 8'($urandom_range(255)), 1'b0, RSP_OK);
      end else begin
         send_item(OP_APPEND, 8'h00, 1'b0, RSP_OK);
      end

      // Read the whole string back, with out-of-phase items mixed in
      while (chars_done < chars_loaded) begin
         if ($urandom_range(99) < 10) begin
            send_readout_noise();
         end else begin
            send_item(OP_READ, 8'($urandom_range(255)), 1'b0, RSP_OK);
         end
      end

      // Read past the end
      hold_until_drained();
      for (i = 0; i < 8; i++) begin
         send_item(OP_READ, 8'($urandom_range(255)), 1'b0, RSP_OK);
      end
      send_readout_noise();

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("loaded %0d bytes in %0d characters, read back %0d bytes",
               byte_count, chars_loaded, delivered_count);
      $display("status counts: ok %0d, full %0d, wrong phase %0d, nothing left %0d",
               status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_PHASE],
               status_tally[ST_EMPTY]);
      if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches, %0d unexpected items", mismatch_count, unexpected_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: utf8_character_reverser.f
rtl/core/ucr_pkg.sv
rtl/core/ucr_req_if.sv
rtl/core/ucr_rsp_if.sv
rtl/core/ucr_ctrl.sv
rtl/core/ucr_datapath.sv
rtl/core/utf8_character_reverser.sv
sim/utf8_character_reverser_test.sv
